// ===== src/ballistic_tuning_step_adapter_macros.svh =====
// Assertion macros shared by the tuning step adapter modules.
`ifndef BALLISTIC_TUNING_STEP_ADAPTER_MACROS_SVH
`define BALLISTIC_TUNING_STEP_ADAPTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define BTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tuning step adapter check failed");
// Check a property on every rising clock edge, reset included.
`define BTS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tuning step adapter check failed");
`else
`define BTS_ASSERT(lbl, prop)
`define BTS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/bts_pkg.sv =====
// Types, constants and ladder tables of the tuning step adapter.
`timescale 1ns / 1ps
package bts_pkg;

  localparam int BTS_LADDER_LEVELS = 10;

  localparam logic [27:0] BTS_FREQ_RESET      = 28'd7100000;
  localparam logic [27:0] BTS_BAND_LOW_RESET  = 28'd7000000;
  localparam logic [27:0] BTS_BAND_HIGH_RESET = 28'd7200000;
  localparam logic [15:0] BTS_DWELL_RESET     = 16'd150;
  localparam logic [15:0] BTS_FAST_RESET      = 16'd70;
  localparam logic [15:0] BTS_TURBO_RESET     = 16'd250;
  localparam logic [3:0]  BTS_STREAK_RESET    = 4'd3;

  typedef enum logic [2:0] {
    REG_BAND_LOW,
    REG_BAND_HIGH,
    REG_DWELL,
    REG_FAST_INTERVAL,
    REG_TURBO_WINDOW,
    REG_STREAK_NEEDED
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIMB,
    ST_FALL,
    ST_FINISH,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic climb;
    logic fall;
    logic finish;
    logic apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic climb_more;
    logic fall_more;
  } sts_t;

  function automatic logic [14:0] ladder_step(input logic [3:0] idx);
    case (idx)
      4'd0:    return 15'd1;
      4'd1:    return 15'd10;
      4'd2:    return 15'd50;
      4'd3:    return 15'd100;
      4'd4:    return 15'd500;
      4'd5:    return 15'd1000;
      4'd6:    return 15'd2000;
      4'd7:    return 15'd5000;
      4'd8:    return 15'd10000;
      default: return 15'd20000;
    endcase
  endfunction

  function automatic logic [13:0] climb_ms(input logic [3:0] idx);
    case (idx)
      4'd0:    return 14'd9999;
      4'd1:    return 14'd260;
      4'd2:    return 14'd200;
      4'd3:    return 14'd160;
      4'd4:    return 14'd120;
      4'd5:    return 14'd95;
      4'd6:    return 14'd80;
      4'd7:    return 14'd65;
      4'd8:    return 14'd55;
      default: return 14'd0;
    endcase
  endfunction

  function automatic logic [13:0] fall_ms(input logic [3:0] idx);
    case (idx)
      4'd0:    return 14'd9999;
      4'd1:    return 14'd320;
      4'd2:    return 14'd250;
      4'd3:    return 14'd200;
      4'd4:    return 14'd160;
      4'd5:    return 14'd130;
      4'd6:    return 14'd110;
      4'd7:    return 14'd90;
      4'd8:    return 14'd75;
      default: return 14'd0;
    endcase
  endfunction

  // floor(300 / max(gap, 50)) clamped to 1..8, as threshold compares
  function automatic logic [2:0] speed_mult(input logic [31:0] gap);
    if (gap <= 32'd50)       return 3'd6;
    else if (gap <= 32'd60)  return 3'd5;
    else if (gap <= 32'd75)  return 3'd4;
    else if (gap <= 32'd100) return 3'd3;
    else if (gap <= 32'd150) return 3'd2;
    else                     return 3'd1;
  endfunction

endpackage

// ===== src/bts_ctrl.sv =====
// Sequencer of the tuning step adapter: walks each item through its steps.
`timescale 1ns / 1ps
`include "ballistic_tuning_step_adapter_macros.svh"
module bts_ctrl
  import bts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CLIMB;
      ST_CLIMB: begin
        if (sts.det_zero) state_nxt = ST_FINISH;
        else if (!sts.climb_more) state_nxt = ST_FALL;
      end
      ST_FALL:   if (!sts.fall_more) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = sts.det_zero ? ST_DONE : ST_APPLY;
      ST_APPLY:  state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CLIMB:  cmd.climb = !sts.det_zero && sts.climb_more;
      ST_FALL:   cmd.fall = sts.fall_more;
      ST_FINISH: cmd.finish = 1'b1;
      ST_APPLY:  cmd.apply = 1'b1;
      ST_DONE: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BTS_ASSERT(a_accept_starts_walk, (in_valid && !in_stall) |=> state_r == ST_CLIMB)
  `BTS_ASSERT(a_done_waits_on_stall, (state_r == ST_DONE && out_valid_r && out_stall) |=> state_r == ST_DONE)
  `BTS_ASSERT_ALWAYS(a_one_command, $onehot0(cmd))

endmodule

// ===== src/bts_datapath.sv =====
// Datapath of the tuning step adapter: settings, tuning state, result register.
`timescale 1ns / 1ps
`include "ballistic_tuning_step_adapter_macros.svh"
module bts_datapath
  import bts_pkg::*;
#(
  parameter int LADDER_LEVELS = BTS_LADDER_LEVELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [27:0]       cfg_data,
  input  logic signed [7:0] in_detent_count,
  input  logic [31:0]       in_time_ms,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [27:0]       out_freq_hz,
  output logic [14:0]       out_step_hz,
  output logic [3:0]        out_step_level
);

  localparam logic [3:0] TOP = 4'(LADDER_LEVELS - 1);

  // settings
  logic [27:0] band_low_r, band_high_r;
  logic [15:0] dwell_r, fast_r, turbo_win_r;
  logic [3:0]  streak_need_r;

  // tuning state
  logic [27:0] freq_r, freq_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] last_move_r, last_det_r;
  logic [31:0] turbo_end_r, turbo_end_nxt;
  logic [3:0]  streak_r, streak_nxt;
  logic        seen_r;

  // per-item working registers
  logic        det_zero_r, det_neg_r, idle_exp_r;
  logic [31:0] now_r, gap_r;
  logic [17:0] prod_r;

  logic [31:0] gap_in, move_ref;
  logic [3:0]  idx_up, streak_inc;
  logic [14:0] step_sel;
  logic [2:0]  mult;
  logic signed [29:0] f_sum, f_lo, f_hi;

  // first item seeds both stored times with its own timestamp
  assign gap_in   = seen_r ? (in_time_ms - last_det_r) : 32'd0;
  assign move_ref = seen_r ? last_move_r : in_time_ms;
  assign idx_up   = idx_r + 4'd1;

  assign sts.det_zero   = det_zero_r;
  assign sts.climb_more = (idx_r < TOP) && (gap_r <= {18'd0, climb_ms(idx_up)});
  assign sts.fall_more  = (idx_r != 4'd0) && (gap_r >= {18'd0, fall_ms(idx_r)});

  always_comb begin
    streak_inc    = streak_r + 4'd1;
    streak_nxt    = streak_r;
    turbo_end_nxt = turbo_end_r;
    if (gap_r < {16'd0, fast_r}) begin
      streak_nxt = streak_inc;
      if (streak_inc >= streak_need_r) begin
        turbo_end_nxt = now_r + {16'd0, turbo_win_r};
        streak_nxt    = 4'd0;
      end
    end else begin
      streak_nxt = 4'd0;
    end
    step_sel = ladder_step(idx_r);
    if ((now_r < turbo_end_nxt) && (idx_r < TOP)) step_sel = ladder_step(idx_up);
    mult = speed_mult(gap_r);
  end

  always_comb begin
    if (det_neg_r) f_sum = signed'({2'b00, freq_r}) - signed'({12'd0, prod_r});
    else           f_sum = signed'({2'b00, freq_r}) + signed'({12'd0, prod_r});
    f_lo = (f_sum < signed'({2'b00, band_low_r})) ? signed'({2'b00, band_low_r}) : f_sum;
    f_hi = (f_lo > signed'({2'b00, band_high_r})) ? signed'({2'b00, band_high_r}) : f_lo;
    freq_nxt = f_hi[27:0];
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.climb) idx_nxt = idx_up;
    else if (cmd.fall) idx_nxt = idx_r - 4'd1;
    else if (cmd.finish && det_zero_r && idle_exp_r) idx_nxt = 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r    <= BTS_BAND_LOW_RESET;
      band_high_r   <= BTS_BAND_HIGH_RESET;
      dwell_r       <= BTS_DWELL_RESET;
      fast_r        <= BTS_FAST_RESET;
      turbo_win_r   <= BTS_TURBO_RESET;
      streak_need_r <= BTS_STREAK_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAND_LOW:      band_low_r    <= cfg_data;
        REG_BAND_HIGH:     band_high_r   <= cfg_data;
        REG_DWELL:         dwell_r       <= cfg_data[15:0];
        REG_FAST_INTERVAL: fast_r        <= cfg_data[15:0];
        REG_TURBO_WINDOW:  turbo_win_r   <= cfg_data[15:0];
        REG_STREAK_NEEDED: streak_need_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= BTS_FREQ_RESET;
      idx_r       <= 4'd0;
      turbo_end_r <= 32'd0;
      streak_r    <= 4'd0;
      seen_r      <= 1'b0;
      det_zero_r  <= 1'b1;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.load) begin
        seen_r     <= 1'b1;
        det_zero_r <= (in_detent_count == 8'sd0);
      end
      if (cmd.finish && !det_zero_r) begin
        streak_r    <= streak_nxt;
        turbo_end_r <= turbo_end_nxt;
      end
      if (cmd.apply) freq_r <= freq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      det_neg_r  <= in_detent_count[7];
      now_r      <= in_time_ms;
      gap_r      <= gap_in;
      idle_exp_r <= (in_time_ms - move_ref) > {16'd0, dwell_r};
      if (in_detent_count != 8'sd0 || !seen_r) begin
        last_det_r  <= in_time_ms;
        last_move_r <= in_time_ms;
      end
    end
    if (cmd.finish) prod_r <= 18'(step_sel) * 18'(mult);
    if (cmd.out_load) begin
      out_freq_hz    <= freq_r;
      out_step_hz    <= ladder_step(idx_r);
      out_step_level <= idx_r;
    end
  end

  `BTS_ASSERT(a_index_in_ladder, idx_r <= TOP)
  `BTS_ASSERT(a_climb_advances, cmd.climb |=> idx_r == 4'($past(idx_r) + 4'd1))
  `BTS_ASSERT(a_fall_retreats, cmd.fall |=> idx_r == 4'($past(idx_r) - 4'd1))

endmodule

// ===== src/ballistic_tuning_step_adapter.sv =====
// Result path: a moving item passes climb, fall, finish and apply before the result register,
// one rung per climb or fall step; an idle tick goes from climb straight to finish and done.
// Throughput: one item in flight; the next transfer is taken once the result is registered.
// Reset (rst_n, synchronous, active low): settings to defaults, frequency 7100000 Hz,
// index 0, streak and turbo end zero, stored times seeded by the first item.
// Top level of the tuning step adapter: sequencer plus datapath.
`timescale 1ns / 1ps
module ballistic_tuning_step_adapter
  import bts_pkg::*;
#(
  parameter int LADDER_LEVELS = BTS_LADDER_LEVELS
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel: transfer when valid and not stalled
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_detent_count,
  input  logic [31:0]       in_time_ms,
  // result channel: transfer when valid and not stalled
  output logic              out_valid,
  input  logic              out_stall,
  output logic [27:0]       out_freq_hz,
  output logic [14:0]       out_step_hz,
  output logic [3:0]        out_step_level,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [27:0]       cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // settings are always writable; the host is to write only while the block is idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  // sequencer: accept, walk the ladder up then down and update streak and frequency for a
  // moving tick, then hold the result in the output register until it is taken
  bts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: settings, ladder index, streak and turbo window, frequency clamp
  bts_datapath #(
    .LADDER_LEVELS (LADDER_LEVELS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_detent_count (in_detent_count),
    .in_time_ms      (in_time_ms),
    .cmd             (cmd),
    .sts             (sts),
    .out_freq_hz     (out_freq_hz),
    .out_step_hz     (out_step_hz),
    .out_step_level  (out_step_level)
  );

endmodule

// ===== test/tb_ballistic_tuning_step_adapter.sv =====
// Self-checking testbench of the tuning step adapter: directed cases, random sweeps, backpressure.
`timescale 1ns / 1ps
module tb_ballistic_tuning_step_adapter;
  import bts_pkg::*;

  // Top rung of the ladder as instantiated (default parameter).
  localparam int unsigned TOP_RUNG = BTS_LADDER_LEVELS - 1;
  // Cycles with no transfer of any kind before the run is declared hung.
  // Slowest correct stretch: the long output hold-off plus one ladder walk and a send gap.
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  // Worst-case latency of a moving item, plus margin.
  localparam int DRAIN_CYCLES = 2 * BTS_LADDER_LEVELS + 12;
  localparam int PHASE_ITEMS = 230;
  localparam int PHASES = 8;
  // Indexes past the last register: the block must take the write and change nothing.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [27:0] freq_hz;
    logic [14:0] step_hz;
    logic [3:0]  step_level;
  } tuning_result_t;

  typedef struct packed {
    logic [7:0]  detents;
    logic [31:0] time_ms;
  } tick_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [7:0] in_detent_count = 8'sd0;
  logic [31:0]       in_time_ms = 32'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [27:0]       out_freq_hz;
  logic [14:0]       out_step_hz;
  logic [3:0]        out_step_level;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = 3'd0;
  logic [27:0]       cfg_data = 28'd0;

  ballistic_tuning_step_adapter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_detent_count(in_detent_count),
    .in_time_ms     (in_time_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_freq_hz    (out_freq_hz),
    .out_step_hz    (out_step_hz),
    .out_step_level (out_step_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 2 ns period: high for 1 ns, low for 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: settings and state of the tuner as the block should hold them.
  // ---------------------------------------------------------------------------
  logic [27:0] band_lo_hz  = BTS_BAND_LOW_RESET;
  logic [27:0] band_hi_hz  = BTS_BAND_HIGH_RESET;
  logic [15:0] dwell_ms    = BTS_DWELL_RESET;
  logic [15:0] fast_ms     = BTS_FAST_RESET;
  logic [15:0] turbo_ms    = BTS_TURBO_RESET;
  logic [3:0]  streak_goal = BTS_STREAK_RESET;

  logic [27:0] tuned_hz       = BTS_FREQ_RESET;
  int unsigned rung           = 0;
  logic [31:0] prev_move_ms   = 32'd0;
  logic [31:0] prev_detent_ms = 32'd0;
  logic [31:0] turbo_end_ms   = 32'd0;
  logic [3:0]  fast_run       = 4'd0;
  logic        seeded         = 1'b0;

  // Step ladder with its climb and fall thresholds; rungs past the tenth saturate.
  function automatic int unsigned rung_step(input int unsigned r);
    case (r)
      0: return 1;      1: return 10;     2: return 50;     3: return 100;
      4: return 500;    5: return 1000;   6: return 2000;   7: return 5000;
      8: return 10000;
      default: return 20000;
    endcase
  endfunction

  function automatic int unsigned rung_climb(input int unsigned r);
    case (r)
      0: return 9999;   1: return 260;    2: return 200;    3: return 160;
      4: return 120;    5: return 95;     6: return 80;     7: return 65;
      8: return 55;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned rung_fall(input int unsigned r);
    case (r)
      0: return 9999;   1: return 320;    2: return 250;    3: return 200;
      4: return 160;    5: return 130;    6: return 110;    7: return 90;
      8: return 75;
      default: return 0;
    endcase
  endfunction

  // Advance the tuner by one tick and return what the block must report for it.
  function automatic tuning_result_t predict_tuning(input logic [7:0] detents,
                                                    input logic [31:0] now);
    logic [31:0]    gap;
    logic [31:0]    since_move;
    int unsigned    step;
    int unsigned    mult;
    int unsigned    span;
    longint         f;
    tuning_result_t r;
    // The very first tick seeds both timestamps, whatever it carries.
    if (!seeded) begin
      prev_move_ms   = now;
      prev_detent_ms = now;
      seeded         = 1'b1;
    end
    if (detents == 8'd0) begin
      // Idle tick: drop to the finest rung once the dwell has run out.
      since_move = now - prev_move_ms;
      if (since_move > {16'd0, dwell_ms}) rung = 0;
    end else begin
      gap            = now - prev_detent_ms;
      prev_detent_ms = now;
      prev_move_ms   = now;
      while (rung < TOP_RUNG && gap <= rung_climb(rung + 1)) rung++;
      while (rung > 0 && gap >= rung_fall(rung)) rung--;
      if (gap < {16'd0, fast_ms}) begin
        fast_run = fast_run + 4'd1;
        if (fast_run >= streak_goal) begin
          turbo_end_ms = now + {16'd0, turbo_ms};
          fast_run     = 4'd0;
        end
      end else begin
        fast_run = 4'd0;
      end
      span = (gap < 32'd50) ? 50 : gap;
      mult = 300 / span;
      if (mult < 1) mult = 1;
      if (mult > 8) mult = 8;
      step = rung_step(rung);
      // Turbo takes the step one rung higher, never past the top.
      if (now < turbo_end_ms && rung < TOP_RUNG) step = rung_step(rung + 1);
      f = longint'(tuned_hz);
      // Only the sign of the detent count matters.
      if (detents[7]) f = f - longint'(step * mult);
      else            f = f + longint'(step * mult);
      // Low clamp first, high clamp second: a crossed band lands on the high limit.
      if (f < longint'(band_lo_hz)) f = longint'(band_lo_hz);
      if (f > longint'(band_hi_hz)) f = longint'(band_hi_hz);
      tuned_hz = f[27:0];
    end
    r.freq_hz    = tuned_hz;
    r.step_hz    = 15'(rung_step(rung) & 32'h7FFF);
    r.step_level = rung[3:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: a queue of pending ticks, driven at the falling edge.
  // ---------------------------------------------------------------------------
  tick_item_t     pending_ticks[$];
  tuning_result_t expected_tuning[$];
  tick_item_t     next_tick;
  tuning_result_t oldest;

  logic     in_taken = 1'b0;
  bit       tx_bursty = 1'b1;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  int       rx_cycle = 0;
  int       idle_cycles = 0;

  int err_count = 0;
  int ticks_taken = 0;
  int results_checked = 0;
  int reg_writes = 0;
  logic [31:0] stream_ms = 32'd0;

  // Record each transfer into the block, predict its result, and plan the next gap.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      expected_tuning.push_back(predict_tuning(in_detent_count, in_time_ms));
      ticks_taken++;
      if (tx_bursty) begin
        if (burst_left == 0) begin
          // End of burst: idle long enough to land anywhere in the block's work.
          gap_left   = $urandom_range(1, 30);
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Hold the payload while it is stalled; advance only after a transfer or while idle.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_ticks.size() > 0) begin
        next_tick = pending_ticks.pop_front();
        in_valid        <= 1'b1;
        in_detent_count <= next_tick.detents;
        in_time_ms      <= next_tick.time_ms;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, long hold-off on request, and the result check.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      // Hold off long enough for the block to fill and stall its input.
      hold_req  = 1'b0;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:  out_stall <= ((rx_cycle % 11) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tuning.size() == 0) begin
        $error("unexpected result: freq_hz %0d step_hz %0d step_level %0d",
               out_freq_hz, out_step_hz, out_step_level);
        err_count++;
      end else begin
        oldest = expected_tuning.pop_front();
        results_checked++;
        if (out_freq_hz !== oldest.freq_hz) begin
          $error("freq_hz: expected %0d, actual %0d", oldest.freq_hz, out_freq_hz);
          err_count++;
        end
        if (out_step_hz !== oldest.step_hz) begin
          $error("step_hz: expected %0d, actual %0d", oldest.step_hz, out_step_hz);
          err_count++;
        end
        if (out_step_level !== oldest.step_level) begin
          $error("step_level: expected %0d, actual %0d", oldest.step_level, out_step_level);
          err_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, expected_tuning.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks.
  // ---------------------------------------------------------------------------

  // Queue one tick and return once the driver has picked it up.
  task automatic send_tick(input logic [7:0] detents, input logic [31:0] t);
    tick_item_t item;
    item.detents = detents;
    item.time_ms = t;
    pending_ticks.push_back(item);
    stream_ms = t;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  // Block is idle: nothing queued, nothing offered, every result delivered.
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_valid || expected_tuning.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [27:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BAND_LOW:      band_lo_hz  = data;
      REG_BAND_HIGH:     band_hi_hz  = data;
      REG_DWELL:         dwell_ms    = data[15:0];
      REG_FAST_INTERVAL: fast_ms     = data[15:0];
      REG_TURBO_WINDOW:  turbo_ms    = data[15:0];
      REG_STREAK_NEEDED: streak_goal = data[3:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed turning: intervals around the ladder thresholds, fast spins
  // that build streaks, idle ticks around the dwell; the rest is jumps and noise.
  task automatic send_random_ticks(input int count);
    int unsigned kind;
    int unsigned span;
    int          spin_left;
    logic [7:0]  detents;
    logic [31:0] t;
    spin_left = 0;
    for (int n = 0; n < count; n++) begin
      kind    = $urandom_range(0, 99);
      detents = 8'($urandom);
      if (spin_left == 0 && kind < 8) spin_left = $urandom_range(4, 24);
      if (spin_left > 0) begin
        spin_left--;
        if (detents == 8'd0) detents = 8'd1;
        t = stream_ms + $urandom_range(0, 65);
      end else begin
        if ($urandom_range(0, 4) == 0) detents = 8'd0;
        if (kind < 45)      span = $urandom_range(0, 90);
        else if (kind < 75) span = $urandom_range(0, 400);
        else if (kind < 88) span = $urandom_range(0, 70000);
        else if (kind < 93) span = $urandom;
        else                span = 0;
        t = stream_ms + span;
        if (kind >= 93 && kind < 98) t = $urandom;
        if (kind >= 98) t = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end
      send_tick(detents, t);
    end
  endtask

  // Random settings; upper data bits of the narrow registers carry random junk.
  task automatic write_random_settings();
    logic [27:0] lo;
    logic [27:0] hi;
    case ($urandom_range(0, 3))
      0: begin
        lo = 28'(28'd7000000 + $urandom_range(0, 100000));
        hi = 28'(lo + $urandom_range(0, 200000));
      end
      1: begin
        lo = 28'($urandom_range(0, 1000));
        hi = 28'(28'd200000000 - $urandom_range(0, 1000));
      end
      2: begin
        lo = 28'($urandom_range(0, 200000000));
        hi = 28'($urandom_range(0, 200000000));
      end
      default: begin
        lo = 28'($urandom_range(7090000, 7110000));
        hi = lo;
      end
    endcase
    write_reg(REG_BAND_LOW, lo);
    write_reg(REG_BAND_HIGH, hi);
    write_reg(REG_DWELL, {12'($urandom), 16'($urandom_range(0, 400))});
    write_reg(REG_FAST_INTERVAL, {12'($urandom), 16'($urandom_range(0, 150))});
    write_reg(REG_TURBO_WINDOW, {12'($urandom), 16'($urandom_range(0, 1000))});
    write_reg(REG_STREAK_NEEDED, {24'($urandom), 4'($urandom)});
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // First tick seeds both timestamps, even an idle one; then a slow detent.
  task automatic test_first_tick_seed();
    send_tick(8'd0, 32'd1000);
    send_tick(8'd1, 32'd1300);
  endtask

  // Climb from a fast interval, zero interval at the top, turbo arming with the
  // default streak, idle ticks either side of the dwell, then slow climb and fall.
  task automatic test_ladder_walk();
    send_tick(8'hFF, 32'd1310);
    send_tick(8'h7F, 32'd1310);
    send_tick(8'h80, 32'd1360);
    send_tick(8'd1,  32'd1400);
    send_tick(8'd0,  32'd1500);
    send_tick(8'd0,  32'd1551);
    send_tick(8'd1,  32'd1700);
    send_tick(8'd1,  32'd1900);
    send_tick(8'd1,  32'd2200);
  endtask

  // Fast streak across the time counter wrap: the wrapped gap still counts as fast, so
  // the streak arms turbo on the first tick after the time has wrapped.
  task automatic test_turbo_time_wrap();
    send_tick(8'd1,  32'hFFFF_FFC0);
    send_tick(8'd1,  32'hFFFF_FFE0);
    send_tick(8'hF0, 32'hFFFF_FFF0);
    send_tick(8'd1,  32'h0000_0010);
    send_tick(8'd0,  32'h0000_0020);
  endtask

  // Crossed band, an empty band at zero, negative result clamp, band at the top.
  task automatic test_band_clamps();
    write_reg(REG_BAND_LOW, 28'd7200000);
    write_reg(REG_BAND_HIGH, 28'd7000000);
    send_tick(8'd1,  32'h0000_0100);
    send_tick(8'h9C, 32'h0000_0140);
    write_reg(REG_BAND_LOW, 28'd0);
    write_reg(REG_BAND_HIGH, 28'd0);
    send_tick(8'd1,  32'h0000_0200);
    write_reg(REG_BAND_HIGH, 28'd200000000);
    send_tick(8'h80, 32'h0000_0210);
    send_tick(8'h7F, 32'h0000_0220);
    write_reg(REG_BAND_LOW, 28'd200000000);
    send_tick(8'd1,  32'h0000_0300);
  endtask

  // With a zero streak goal every fast detent arms turbo.
  task automatic test_zero_streak();
    write_reg(REG_STREAK_NEEDED, 28'd0);
    write_reg(REG_BAND_LOW, 28'd7000000);
    write_reg(REG_BAND_HIGH, 28'd7200000);
    send_tick(8'd1,  32'h0000_0400);
    send_tick(8'd1,  32'h0000_0410);
    send_tick(8'hFF, 32'h0000_0420);
  endtask

  // Phases of settings, extremes first, each with its own sender and receiver style.
  task automatic test_random_settings();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_BAND_LOW, 28'd0);
          write_reg(REG_BAND_HIGH, 28'd200000000);
          write_reg(REG_DWELL, 28'd0);
          write_reg(REG_FAST_INTERVAL, 28'd0);
          write_reg(REG_TURBO_WINDOW, 28'd0);
          write_reg(REG_STREAK_NEEDED, 28'd15);
        end
        1: begin
          write_reg(REG_BAND_LOW, 28'd7000000);
          write_reg(REG_BAND_HIGH, 28'd7200000);
          write_reg(REG_DWELL, 28'hFFF_FFFF);
          write_reg(REG_FAST_INTERVAL, 28'd65535);
          write_reg(REG_TURBO_WINDOW, 28'd65535);
          write_reg(REG_STREAK_NEEDED, 28'd1);
          write_reg(REG_SPARE_A, 28'($urandom));
          write_reg(REG_SPARE_B, 28'($urandom));
        end
        default: write_random_settings();
      endcase
      rx_mode   = rx_mode_t'(p % 4);
      // Two phases run back to back with no gaps on the sender.
      tx_bursty = (p != 2 && p != 5);
      send_random_ticks(PHASE_ITEMS);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering ticks.
  task automatic test_output_hold_off();
    wait_idle();
    rx_mode   = RX_OPEN;
    tx_bursty = 1'b0;
    hold_req  = 1'b1;
    send_random_ticks(20);
    tx_bursty = 1'b1;
  endtask

  initial begin
    // Synchronous reset, released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_tick_seed();
    test_ladder_walk();
    test_turbo_time_wrap();
    test_band_clamps();
    test_zero_streak();
    test_random_settings();
    test_output_hold_off();

    // Drain: every queued tick taken and every result back, then let the block settle.
    while (pending_ticks.size() != 0 || in_valid || expected_tuning.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks and %0d checked results with %0d register writes,",
             ticks_taken, results_checked, reg_writes);
    $display("over %0d setting phases, time wrap, band clamps and a %0d-cycle output hold-off.",
             PHASES, HOLD_OFF_CYCLES);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
